// File: rtl/ccrc_pkg.sv
// Package for the chunked CRC-16 engine: constants, the queue entry type,
// the back-end state type and the CRC byte update function. No dependencies.
package ccrc_pkg;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CHUNK_SIZE_INIT = 16'd64;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
    localparam int          QUEUE_DEPTH     = 4;
    localparam int          QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int          QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    // One classified word on its way from the front end to the back end.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;          // closes the current chunk
        logic        eof;           // closes the stream
        logic [15:0] pad;           // zero bytes to append after this word
        logic [15:0] chunk_number;
        logic [15:0] valid_bytes;
    } t_chunk_entry;

    typedef enum logic {
        BK_RUN,
        BK_PAD
    } t_back_state;

    // CRC-16/CCITT-FALSE update by one byte, polynomial 0x1021, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ (x >> 4);
        return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
    endfunction

endpackage

// File: rtl/ccrc_ifs.sv
// Handshake channel interfaces of the chunked CRC-16 engine.
// Self-contained; used by the top level and the back end.
interface ccrc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;
    modport source (output valid, data_byte, end_of_file, input ready);
    modport sink   (input valid, data_byte, end_of_file, output ready);
endinterface

interface ccrc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] chunk_number;
    logic [15:0] valid_bytes;
    logic [15:0] crc_value;
    logic        final_chunk;
    modport source (output valid, chunk_number, valid_bytes, crc_value, final_chunk,
                    input ready);
    modport sink   (input valid, chunk_number, valid_bytes, crc_value, final_chunk,
                    output ready);
endinterface

interface ccrc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] chunk_size;
    modport source (output valid, chunk_size, input ready);
    modport sink   (input valid, chunk_size, output ready);
endinterface

// File: rtl/ccrc_front.sv
// Front end: accepts stream words, tracks chunk position and numbering,
// and tags each word with its chunk-closing information. Uses ccrc_pkg.
module ccrc_front
    import ccrc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [15:0]  i_chunk_size,
    input  logic         i_valid,
    input  logic [7:0]   i_data_byte,
    input  logic         i_end_of_file,
    input  logic         i_full,
    output logic         o_ready,
    output logic         o_push,
    output t_chunk_entry o_entry
);

    logic [15:0] r_bytes_in_chunk, n_bytes_in_chunk;
    logic [15:0] r_chunk_counter,  n_chunk_counter;
    logic [15:0] size_eff;
    logic [15:0] count;
    logic [15:0] chunk_num;
    logic        chunk_end;

    always_comb begin
        size_eff  = (i_chunk_size == 16'd0) ? 16'd1 : i_chunk_size;
        count     = (r_bytes_in_chunk != COUNT_MAX) ? r_bytes_in_chunk + 16'd1
                                                    : r_bytes_in_chunk;
        chunk_num = (r_chunk_counter != COUNT_MAX) ? r_chunk_counter + 16'd1
                                                   : r_chunk_counter;
        chunk_end = i_end_of_file || (count >= size_eff);

        o_ready = !i_full;
        o_push  = i_valid && !i_full;

        o_entry.data         = i_data_byte;
        o_entry.last         = chunk_end;
        o_entry.eof          = i_end_of_file;
        o_entry.pad          = (chunk_end && (size_eff > count)) ? size_eff - count : 16'd0;
        o_entry.chunk_number = chunk_num;
        o_entry.valid_bytes  = count;

        n_bytes_in_chunk = r_bytes_in_chunk;
        n_chunk_counter  = r_chunk_counter;
        if (o_push) begin
            if (chunk_end) begin
                n_bytes_in_chunk = 16'd0;
                n_chunk_counter  = i_end_of_file ? 16'd0 : chunk_num;
            end else begin
                n_bytes_in_chunk = count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_in_chunk <= 16'd0;
            r_chunk_counter  <= 16'd0;
        end else begin
            r_bytes_in_chunk <= n_bytes_in_chunk;
            r_chunk_counter  <= n_chunk_counter;
        end
    end

endmodule

// File: rtl/ccrc_queue.sv
// Short first-in first-out queue of classified words between front and back.
// Uses ccrc_pkg for the entry type and depth.
module ccrc_queue
    import ccrc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_chunk_entry i_entry,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_empty,
    output t_chunk_entry o_head
);

    t_chunk_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]       r_count,  n_count;

    always_comb begin
        o_full   = (r_count == QCNT_W'(QUEUE_DEPTH));
        o_empty  = (r_count == '0);
        o_head   = r_mem[r_rd_ptr];
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: rtl/ccrc_back.sv
// Back end: runs the CRC over queued words, appends zero padding and holds
// each finished result in an output register. Uses ccrc_pkg and ccrc_ifs.
module ccrc_back
    import ccrc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_chunk_entry       i_head,
    output logic               o_pop,
    ccrc_result_if.source      o_result
);

    t_back_state r_state, n_state;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_pad, n_pad;
    logic [15:0] r_chunk_number, n_chunk_number;
    logic [15:0] r_valid_bytes,  n_valid_bytes;
    logic        r_eof, n_eof;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_chunk_number, n_out_chunk_number;
    logic [15:0] r_out_valid_bytes,  n_out_valid_bytes;
    logic [15:0] r_out_crc,          n_out_crc;
    logic        r_out_final,        n_out_final;
    logic        out_free;
    logic [15:0] crc_next;

    assign o_result.valid        = r_out_valid;
    assign o_result.chunk_number = r_out_chunk_number;
    assign o_result.valid_bytes  = r_out_valid_bytes;
    assign o_result.crc_value    = r_out_crc;
    assign o_result.final_chunk  = r_out_final;

    always_comb begin
        out_free = !r_out_valid || o_result.ready;
        crc_next = crc_byte(r_crc, (r_state == BK_PAD) ? 8'h00 : i_head.data);

        n_state            = r_state;
        n_crc              = r_crc;
        n_pad              = r_pad;
        n_chunk_number     = r_chunk_number;
        n_valid_bytes      = r_valid_bytes;
        n_eof              = r_eof;
        n_out_valid        = r_out_valid && !o_result.ready;
        n_out_chunk_number = r_out_chunk_number;
        n_out_valid_bytes  = r_out_valid_bytes;
        n_out_crc          = r_out_crc;
        n_out_final        = r_out_final;
        o_pop              = 1'b0;

        case (r_state)
            BK_RUN: begin
                if (!i_empty) begin
                    if (!i_head.last) begin
                        o_pop = 1'b1;
                        n_crc = crc_next;
                    end else if (i_head.pad != 16'd0) begin
                        o_pop          = 1'b1;
                        n_crc          = crc_next;
                        n_pad          = i_head.pad;
                        n_chunk_number = i_head.chunk_number;
                        n_valid_bytes  = i_head.valid_bytes;
                        n_eof          = i_head.eof;
                        n_state        = BK_PAD;
                    end else if (out_free) begin
                        o_pop              = 1'b1;
                        n_crc              = CRC_INIT;
                        n_out_valid        = 1'b1;
                        n_out_chunk_number = i_head.chunk_number;
                        n_out_valid_bytes  = i_head.valid_bytes;
                        n_out_crc          = crc_next;
                        n_out_final        = i_head.eof;
                    end
                end
            end
            BK_PAD: begin
                // The last zero byte is folded in on the cycle the result is loaded.
                if (r_pad > 16'd1) begin
                    n_crc = crc_next;
                    n_pad = r_pad - 16'd1;
                end else if (out_free) begin
                    n_crc              = CRC_INIT;
                    n_out_valid        = 1'b1;
                    n_out_chunk_number = r_chunk_number;
                    n_out_valid_bytes  = r_valid_bytes;
                    n_out_crc          = crc_next;
                    n_out_final        = r_eof;
                    n_state            = BK_RUN;
                end
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pad              <= n_pad;
        r_chunk_number     <= n_chunk_number;
        r_valid_bytes      <= n_valid_bytes;
        r_eof              <= n_eof;
        r_out_chunk_number <= n_out_chunk_number;
        r_out_valid_bytes  <= n_out_valid_bytes;
        r_out_crc          <= n_out_crc;
        r_out_final        <= n_out_final;
    end

endmodule

// File: rtl/chunked_crc16_engine_top.sv
// Top level of the chunked CRC-16 engine; instantiates front end, queue and
// back end. Depends on ccrc_pkg and the channel interfaces in ccrc_ifs.
//
// The engine cuts a byte stream into chunks of chunk_size bytes (a size of
// zero acts as one) and reports CRC-16/CCITT-FALSE over each chunk. A chunk
// closes on its last byte or on a word flagged end_of_file; a short final
// chunk is padded with zero bytes so the CRC spans at least chunk_size bytes.
// Each result carries the one-based chunk number (saturating at 65535), the
// number of real bytes, the CRC and a flag for the chunk that ends the stream;
// after that chunk the numbering restarts. Input words are taken at one per
// cycle while the queue is not full. A chunk that needs padding keeps the
// back end busy after its closing word while the CRC unit folds in the zero
// bytes, one byte per cycle, and the last zero byte goes in as the result is
// loaded; a four-entry queue lets the front end keep taking words meanwhile
// until it fills. Results sit in an output register, so a stalled consumer
// only blocks the engine once a second result is ready. The chunk size
// register resets to 64 and may be written at any time the engine is idle;
// its channel is always ready.
module chunked_crc16_engine_top
    import ccrc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ccrc_cfg_if.sink      i_cfg,
    ccrc_byte_if.sink     i_byte,
    ccrc_result_if.source o_result
);

    logic [15:0]   r_chunk_size;
    t_chunk_entry  push_entry;
    t_chunk_entry  head_entry;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;

    // Configuration writes are always accepted.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_size <= CHUNK_SIZE_INIT;
        end else if (i_cfg.valid) begin
            r_chunk_size <= i_cfg.chunk_size;
        end
    end

    // Front end classifies each word and decides where chunks close.
    ccrc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_chunk_size  (r_chunk_size),
        .i_valid       (i_byte.valid),
        .i_data_byte   (i_byte.data_byte),
        .i_end_of_file (i_byte.end_of_file),
        .i_full        (q_full),
        .o_ready       (i_byte.ready),
        .o_push        (q_push),
        .o_entry       (push_entry)
    );

    ccrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_entry)
    );

    // Back end computes the CRC, including padding, and holds the result.
    ccrc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_head   (head_entry),
        .o_pop    (q_pop),
        .o_result (o_result)
    );

    // The front end never writes into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    // The back end never takes a word from an empty queue.
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    // Every reported chunk holds at least one real byte and a nonzero number.
    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.valid_bytes != 16'd0) &&
                           (o_result.chunk_number != 16'd0))
        else $error("result with empty chunk or zero chunk number");

endmodule

// File: bench/tb_chunked_crc16_engine_top.sv
// Self-checking testbench for chunked_crc16_engine_top: directed and random byte
// streams, a bit-serial CRC predictor and a scoreboard of expected chunk results.
// Depends on ccrc_pkg and the channel interfaces in ccrc_ifs.
module tb_chunked_crc16_engine_top
    import ccrc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam int          MAX_WAIT     = 13;
    localparam int          DRAIN_GAP    = 20;
    localparam int          HOLD_CYCLES  = 300;
    // The slowest legal stretch without any accepted word is one maximum
    // size chunk being zero padded; allow four times that.
    localparam int          STALL_LIMIT  = 4 * 65536;
    localparam int          RANDOM_WORDS = 1420;
    localparam int          MAX_PRINTED  = 200;

    typedef struct {
        bit [15:0] chunk_number;
        bit [15:0] valid_bytes;
        bit [15:0] crc_value;
        bit        final_chunk;
    } t_chunk_result;

    logic i_clk;
    logic i_rst_n;

    ccrc_cfg_if    cfg_ch();
    ccrc_byte_if   byte_ch();
    ccrc_result_if result_ch();

    chunked_crc16_engine_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    // Predictor state: running CRC of the open chunk, real bytes taken into it,
    // chunks closed in the current stream, and the programmed chunk size.
    bit [15:0] crc_acc;
    bit [15:0] bytes_taken;
    bit [15:0] chunks_done;
    bit [15:0] size_reg;

    t_chunk_result pending_chunks[$];

    int fail_count;
    int idle_cycles;
    bit tx_idle;
    bit rx_idle;
    bit rx_hold;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // MSB-first CRC-16 update, one bit per iteration.
    function automatic bit [15:0] crc_fold(input bit [15:0] crc, input bit [7:0] b);
        bit [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Folds one accepted word into the open chunk. Returns 1 and fills r when
    // the word closes a chunk; a short chunk is zero padded up to the size.
    function automatic bit close_chunk_on_byte(input bit [7:0] b, input bit eof,
                                               output t_chunk_result r);
        int span;
        int n;
        span = (size_reg == 16'd0) ? 1 : int'(size_reg);
        crc_acc = crc_fold(crc_acc, b);
        if (bytes_taken != COUNT_MAX) begin
            bytes_taken++;
        end
        n = int'(bytes_taken);
        if (n < span && !eof) begin
            return 1'b0;
        end
        // A size lowered below the bytes already taken closes the chunk here
        // without padding, since n already exceeds span.
        while (n < span) begin
            crc_acc = crc_fold(crc_acc, 8'h00);
            n++;
        end
        if (chunks_done != COUNT_MAX) begin
            chunks_done++;
        end
        r.chunk_number = chunks_done;
        r.valid_bytes  = bytes_taken;
        r.crc_value    = crc_acc;
        r.final_chunk  = eof;
        crc_acc     = CRC_INIT;
        bytes_taken = '0;
        if (eof) begin
            chunks_done = '0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTED) begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endtask

    // Offers one word, after a random gap when tx_idle is set, and waits for the handshake.
    task automatic send_byte(input bit [7:0] b, input bit eof);
        int gap;
        t_chunk_result r;
        gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= b;
        byte_ch.end_of_file <= eof;
        do @(posedge i_clk); while (!byte_ch.ready);
        if (close_chunk_on_byte(b, eof, r)) begin
            pending_chunks.push_back(r);
        end
    endtask

    // Stops offering words and waits until every expected chunk has arrived,
    // then lets the queue drain words that close no chunk.
    task automatic wait_engine_idle();
        byte_ch.valid <= 1'b0;
        while (pending_chunks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_chunk_size(input bit [15:0] size);
        wait_engine_idle();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.chunk_size <= size;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        size_reg = size;
    endtask

    // Result sink: a random wait before each word when rx_idle is set, or a long hold when asked.
    initial begin : result_sink
        int wait_n;
        result_ch.ready <= 1'b0;
        forever begin
            if (rx_hold) begin
                result_ch.ready <= 1'b0;
                @(posedge i_clk);
            end else begin
                wait_n = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
                if (wait_n != 0) begin
                    result_ch.ready <= 1'b0;
                    repeat (wait_n) @(posedge i_clk);
                end
                result_ch.ready <= 1'b1;
                do @(posedge i_clk); while (!result_ch.valid && !rx_hold);
            end
        end
    end

    // Scoreboard: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_chunk_result e;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_chunks.size() == 0) begin
                report_mismatch($sformatf("unexpected result chunk %0d crc %h",
                                          result_ch.chunk_number, result_ch.crc_value));
            end else begin
                e = pending_chunks.pop_front();
                if (result_ch.chunk_number !== e.chunk_number)
                    report_mismatch($sformatf("chunk_number %0d, expected %0d",
                                              result_ch.chunk_number, e.chunk_number));
                if (result_ch.valid_bytes !== e.valid_bytes)
                    report_mismatch($sformatf("valid_bytes %0d, expected %0d (chunk %0d)",
                                              result_ch.valid_bytes, e.valid_bytes,
                                              e.chunk_number));
                if (result_ch.crc_value !== e.crc_value)
                    report_mismatch($sformatf("crc_value %h, expected %h (chunk %0d)",
                                              result_ch.crc_value, e.crc_value,
                                              e.chunk_number));
                if (result_ch.final_chunk !== e.final_chunk)
                    report_mismatch($sformatf("final_chunk %b, expected %b (chunk %0d)",
                                              result_ch.final_chunk, e.final_chunk,
                                              e.chunk_number));
            end
        end
    end

    // Watchdog: ends the run when no word moves on any channel for too long.
    always @(posedge i_clk) begin : watchdog
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Reset size of 64: a short stream that gets heavily padded.
    task automatic test_default_size();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
    endtask

    // One-byte chunks, and a size of zero that behaves as one.
    task automatic test_tiny_chunks();
        write_chunk_size(16'd1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        write_chunk_size(16'd0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7E, 1'b1);
    endtask

    // A stream ending exactly on a chunk boundary, then one ending mid-chunk.
    task automatic test_chunk_boundaries();
        write_chunk_size(16'd4);
        for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(0, 255)), i == 3);
        for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(0, 255)), i == 5);
    endtask

    // Size written below the bytes already taken: the next word closes the
    // chunk with no padding.
    task automatic test_size_lowered_mid_chunk();
        write_chunk_size(16'd8);
        for (int i = 0; i < 5; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
        write_chunk_size(16'd3);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Largest size: each stream end pads to 65535 bytes.
    task automatic test_largest_chunk();
        write_chunk_size(16'hFFFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h3C, 1'b1);
    endtask

    // The sink holds off long enough for the engine to fill and stall its
    // input; later the source pauses mid-chunk until every result is in.
    task automatic test_backpressure();
        write_chunk_size(16'd3);
        tx_idle = 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_engine_idle();
        tx_idle = 1'b1;
        for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(0, 255)), i == 3);
    endtask

    // Random phases: a new size each phase, mostly small, with streams of
    // random length and an occasional early end of file. Streams may run
    // across phases, so sizes also change inside open chunks.
    task automatic test_random_streams();
        int sent;
        int phase_len;
        int left;
        int hi;
        int mode;
        bit [15:0] size;
        bit eof;
        sent = 0;
        left = 0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 15))
                0: begin
                    size = 16'd0;
                end
                1: begin
                    size = 16'd1;
                end
                2: begin
                    size = 16'($urandom_range(100, 400));
                end
                default: begin
                    size = 16'($urandom_range(2, 24));
                end
            endcase
            write_chunk_size(size);
            mode = $urandom_range(0, 3);
            tx_idle = mode[0];
            rx_idle = mode[1];
            phase_len = $urandom_range(20, 120);
            repeat (phase_len) begin
                if (left == 0) begin
                    hi = 3 * int'(size) + 2;
                    if (hi > 150) hi = 150;
                    left = $urandom_range(1, hi);
                end
                left--;
                eof = (left == 0) || ($urandom_range(0, 39) == 0);
                if (eof) left = 0;
                send_byte(8'($urandom_range(0, 255)), eof);
                sent++;
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin : main
        fail_count  = 0;
        idle_cycles = 0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        rx_hold     = 1'b0;
        size_reg    = CHUNK_SIZE_INIT;
        crc_acc     = CRC_INIT;
        bytes_taken = '0;
        chunks_done = '0;

        i_rst_n             <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.chunk_size   <= '0;
        byte_ch.valid       <= 1'b0;
        byte_ch.data_byte   <= '0;
        byte_ch.end_of_file <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_size();
        test_tiny_chunks();
        test_chunk_boundaries();
        test_size_lowered_mid_chunk();
        test_largest_chunk();
        test_backpressure();
        test_random_streams();

        wait_engine_idle();
        if (pending_chunks.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_chunks.size()));
        end
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/ccrc_pkg.sv
rtl/ccrc_ifs.sv
rtl/ccrc_front.sv
rtl/ccrc_queue.sv
rtl/ccrc_back.sv
rtl/chunked_crc16_engine_top.sv
bench/tb_chunked_crc16_engine_top.sv
